@@ rtl/sacl_pkg.sv @@
// Shared types and constants for the set-associative tag lookup block.
package sacl_pkg;

    // One stored line: valid flag and tag.
    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
    } entry_t;

    localparam int ADDR_W       = 32;
    localparam int CNT_W        = 32;
    localparam int WAY_W        = 11;
    localparam int MAX_WAYS_LOG2 = 11;
    localparam int TDATA_IN_W   = 32;
    localparam int TDATA_OUT_W  = 80;  // 77 bits of fields, padded to bytes

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd2;

    localparam logic [2:0]  LINE_SIZE_RST = 3'd4;
    localparam logic [3:0]  WAYS_RST      = 4'd3;
    localparam logic [15:0] LFSR_MASK     = 16'hB400;
    localparam logic [15:0] LFSR_ZERO_SUB = 16'hACE1;

endpackage

@@ rtl/sacl_tag_store.sv @@
// Tag store: one synchronous memory of valid/tag entries with a clearing pass after reset.
module sacl_tag_store #(
    parameter int LINE_COUNT = 2048,
    parameter int IDX_W      = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IDX_W-1:0]     rd_addr,
    output sacl_pkg::entry_t     rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  sacl_pkg::entry_t     wr_data,
    output logic                 clr_busy
);
    import sacl_pkg::*;

    entry_t           mem [LINE_COUNT];
    entry_t           rd_data_reg;
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;

    always_comb begin
        if (clr_busy_reg) begin
            mem_we = 1'b1;
            mem_wa = clr_idx_reg;
            mem_wd = '0;
        end else begin
            mem_we = wr_en;
            mem_wa = wr_addr;
            mem_wd = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sweep every entry once after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(LINE_COUNT - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

@@ rtl/set_assoc_cache_tag_lookup.sv @@
// Set-associative tag lookup with random replacement: one result per request address.
// Each request address is split into offset, set and tag by the configured line size and
// associativity; the set's ways are read one per cycle from a single-port-read tag memory,
// so the way count sets how long a request takes. A new request is taken while the last
// result still waits in the output register. After reset the tag memory is swept once
// before the first request is taken; configuration writes are taken throughout.
// LINE_COUNT must be a power of two. On a miss the first invalid way is filled, otherwise
// a victim comes from a 16-bit Galois LFSR that steps only on such an eviction.
module set_assoc_cache_tag_lookup #(
    parameter int LINE_COUNT = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request: [31:0] address
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sacl_pkg::TDATA_IN_W-1:0]     s_tdata,
    // result: [0] hit, [11:1] way_used, [12] replaced_valid, [44:13] hit_total,
    // [76:45] miss_total, [79:77] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sacl_pkg::TDATA_OUT_W-1:0]    m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import sacl_pkg::*;

    localparam int IDX_W  = $clog2(LINE_COUNT);
    localparam int WCNT_W = IDX_W + 1;
    localparam int MAX_WL = (IDX_W < MAX_WAYS_LOG2) ? IDX_W : MAX_WAYS_LOG2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [2:0]        line_size_reg;
    logic [3:0]        ways_reg;
    logic [15:0]       lfsr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [WCNT_W-1:0] issue_reg, issue_next;
    logic              chk_en_reg;
    logic [IDX_W-1:0]  chk_way_reg;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_way_reg, free_way_next;
    logic              res_hit_reg;
    logic [WAY_W-1:0]  res_way_reg;
    logic              res_evict_reg;
    logic [CNT_W-1:0]  hit_cnt_reg, miss_cnt_reg;
    logic              m_tvalid_reg;
    logic [TDATA_OUT_W-1:0] m_tdata_reg;

    logic [3:0]        wl_eff;
    logic [WCNT_W-1:0] ways_cnt;
    logic [IDX_W-1:0]  ways_m1;
    logic [ADDR_W-1:0] block;
    logic [3:0]        tag_shift;
    logic [ADDR_W-1:0] tag;
    logic [IDX_W-1:0]  base;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    logic              clr_busy;
    logic              in_fire;
    logic              issue_go;
    logic              hit_now, last_now, finish, free_any, evict;
    logic [IDX_W-1:0]  fin_way;
    logic [15:0]       lfsr_step;
    logic [15:0]       seed_load;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    assign wl_eff    = (ways_reg > 4'(MAX_WL)) ? 4'(MAX_WL) : ways_reg;
    assign ways_cnt  = WCNT_W'(1) << wl_eff;
    assign ways_m1   = IDX_W'(ways_cnt - 1'b1);
    assign block     = addr_reg >> line_size_reg;
    assign tag_shift = 4'(IDX_W) - wl_eff;
    assign tag       = block >> tag_shift;
    assign base      = IDX_W'(block[IDX_W-1:0] << wl_eff);
    assign rd_addr   = base | issue_reg[IDX_W-1:0];

    assign s_tready  = (state_reg == ST_IDLE) && !clr_busy;
    assign in_fire   = s_tvalid && s_tready;
    assign issue_go  = (state_reg == ST_SCAN) && (issue_reg < ways_cnt);

    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
    assign seed_load = (cfg_wdata == 16'd0) ? LFSR_ZERO_SUB : cfg_wdata;

    always_comb begin
        hit_now  = (state_reg == ST_SCAN) && chk_en_reg && rd_data.valid && (rd_data.tag == tag);
        last_now = (state_reg == ST_SCAN) && chk_en_reg && (chk_way_reg == ways_m1);
        finish   = hit_now || last_now;
        free_any = free_found_reg || !rd_data.valid;
        evict    = !hit_now && !free_any;
        if (hit_now) begin
            fin_way = chk_way_reg;
        end else if (free_found_reg) begin
            fin_way = free_way_reg;
        end else if (!rd_data.valid) begin
            fin_way = chk_way_reg;
        end else begin
            fin_way = lfsr_step[IDX_W-1:0] & ways_m1;
        end
        wr_en         = last_now && !hit_now;
        wr_addr       = base | fin_way;
        wr_data.valid = 1'b1;
        wr_data.tag   = tag;
    end

    // Track the first invalid way seen during the scan and advance the way issue counter.
    always_comb begin
        free_found_next = free_found_reg;
        free_way_next   = free_way_reg;
        issue_next      = issue_reg;
        if (in_fire) begin
            free_found_next = 1'b0;
            issue_next      = '0;
        end else begin
            if (issue_go) begin
                issue_next = issue_reg + 1'b1;
            end
            if ((state_reg == ST_SCAN) && chk_en_reg && !rd_data.valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_way_next   = chk_way_reg;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_SCAN;
            ST_SCAN: if (finish) state_next = ST_FIN;
            ST_FIN:  if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    sacl_tag_store #(
        .LINE_COUNT (LINE_COUNT),
        .IDX_W      (IDX_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .clr_busy (clr_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            line_size_reg  <= LINE_SIZE_RST;
            ways_reg       <= WAYS_RST;
            lfsr_reg       <= LFSR_ZERO_SUB;
            chk_en_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            issue_reg      <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            chk_en_reg     <= issue_go && !in_fire;
            free_found_reg <= free_found_next;
            issue_reg      <= issue_next;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_LINE_SIZE: line_size_reg <= cfg_wdata[2:0];
                    CFG_WAYS:      ways_reg      <= cfg_wdata[3:0];
                    CFG_SEED:      lfsr_reg      <= seed_load;
                    default:       ;
                endcase
            end else if (finish && evict) begin
                lfsr_reg <= lfsr_step;
            end

            if (hit_now && hit_cnt_reg != '1) begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
            end
            if (wr_en && miss_cnt_reg != '1) begin
                miss_cnt_reg <= miss_cnt_reg + 1'b1;
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if ((state_reg == ST_FIN) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            addr_reg <= s_tdata;
        end
        chk_way_reg  <= issue_reg[IDX_W-1:0];
        free_way_reg <= free_way_next;
        if (finish) begin
            res_hit_reg   <= hit_now;
            res_way_reg   <= WAY_W'(fin_way);
            res_evict_reg <= evict;
        end
        if ((state_reg == ST_FIN) && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {3'b000, miss_cnt_reg, hit_cnt_reg, res_evict_reg,
                            res_way_reg, res_hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/sacl_checker.sv @@
// Port-level checks for the tag lookup block, bound to its top level.
module sacl_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sacl_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import sacl_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The counter of the reported kind includes this request.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] ? (m_tdata[44:13] != '0) : (m_tdata[76:45] != '0)))
        else $error("result counter does not include this request");

    // An eviction only happens on a miss.
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> !m_tdata[0])
        else $error("eviction reported on a hit");

    // One request at a time: no back-to-back accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one in flight");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind set_assoc_cache_tag_lookup sacl_checker u_sacl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/tb.sv @@
// Testbench for set_assoc_cache_tag_lookup: random and directed lookups checked by a scoreboard.
`timescale 1ns / 100ps

module tb;
    import sacl_pkg::*;

    localparam int LINES = 2048;
    localparam int LOG2_LINES = 11;
    localparam logic [15:0] SEED_RST = 16'hACE1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    // Fields of one result, hit in the lowest bit.
    typedef struct packed {
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] hit_total;
        logic             replaced_valid;
        logic [WAY_W-1:0] way_used;
        logic             hit;
    } lookup_result_t;

    function automatic int unsigned effective_ways_log2(logic [3:0] sel);
        int unsigned wl;
        wl = 32'(sel);
        if (wl > MAX_WAYS_LOG2) wl = MAX_WAYS_LOG2;
        if (wl > LOG2_LINES) wl = LOG2_LINES;
        return wl;
    endfunction

    class lookup_scoreboard;
        logic [2:0]       offset_bits;
        logic [3:0]       ways_sel;
        logic [15:0]      replace_lfsr;
        bit               line_valid [LINES];
        logic [31:0]      line_tag [LINES];
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] miss_count;
        lookup_result_t   expected_lookups [$];
        int               errors;

        function new();
            offset_bits = LINE_SIZE_RST;
            ways_sel = WAYS_RST;
            replace_lfsr = SEED_RST;
            hit_count = '0;
            miss_count = '0;
            errors = 0;
            foreach (line_tag[i]) begin
                line_valid[i] = 1'b0;
                line_tag[i] = '0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LINE_SIZE: offset_bits = value[2:0];
                CFG_WAYS: ways_sel = value[3:0];
                CFG_SEED: replace_lfsr = (value == '0) ? LFSR_ZERO_SUB : value;
                default: ;
            endcase
        endfunction

        function lookup_result_t predict_lookup(logic [31:0] addr);
            lookup_result_t res;
            int unsigned wl, set_bits, base;
            logic [31:0] blk, tag;
            bit found;
            wl = effective_ways_log2(ways_sel);
            set_bits = LOG2_LINES - wl;
            blk = addr >> offset_bits;
            tag = blk >> set_bits;
            base = (blk & ((32'(1) << set_bits) - 1)) << wl;
            res = '0;
            found = 1'b0;
            for (int w = 0; w < (1 << wl); w++) begin
                if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
                    found = 1'b1;
                    res.way_used = WAY_W'(w);
                end
            end
            res.hit = found;
            if (found) begin
                if (hit_count != '1) hit_count++;
            end else begin
                if (miss_count != '1) miss_count++;
                for (int w = 0; w < (1 << wl); w++) begin
                    if (!found && !line_valid[base + w]) begin
                        found = 1'b1;
                        res.way_used = WAY_W'(w);
                    end
                end
                // Set is full: step the LFSR, then take its low bits as victim.
                if (!found) begin
                    replace_lfsr = replace_lfsr[0] ? ((replace_lfsr >> 1) ^ LFSR_MASK)
                                                   : (replace_lfsr >> 1);
                    res.way_used = WAY_W'(replace_lfsr & ((1 << wl) - 1));
                    res.replaced_valid = 1'b1;
                end
                line_valid[base + res.way_used] = 1'b1;
                line_tag[base + res.way_used] = tag;
            end
            res.hit_total = hit_count;
            res.miss_total = miss_count;
            return res;
        endfunction

        function void note_request(logic [31:0] addr);
            expected_lookups.push_back(predict_lookup(addr));
        endfunction

        function void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10)
                $display("mismatch in %s: expected %h, got %h", field, want, got);
        endfunction

        function void check_result(logic [TDATA_OUT_W-1:0] data);
            lookup_result_t got, want;
            got = lookup_result_t'(data[76:0]);
            if (expected_lookups.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result %h with no request pending", data);
                return;
            end
            want = expected_lookups.pop_front();
            if (got.hit !== want.hit) note_mismatch("hit", 32'(want.hit), 32'(got.hit));
            if (got.way_used !== want.way_used)
                note_mismatch("way_used", 32'(want.way_used), 32'(got.way_used));
            if (got.replaced_valid !== want.replaced_valid)
                note_mismatch("replaced_valid", 32'(want.replaced_valid),
                              32'(got.replaced_valid));
            if (got.hit_total !== want.hit_total)
                note_mismatch("hit_total", want.hit_total, got.hit_total);
            if (got.miss_total !== want.miss_total)
                note_mismatch("miss_total", want.miss_total, got.miss_total);
            if (data[79:77] !== 3'b000) note_mismatch("padding", 32'd0, 32'(data[79:77]));
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;   // [31:0] address
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [0] hit, [11:1] way_used, [12] replaced_valid, [44:13] hit_total, [76:45] miss_total
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    lookup_scoreboard board = new();

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_ticket = 0;
    int          quiet_cycles = 0;
    logic [2:0]  cur_ls = LINE_SIZE_RST;
    logic [3:0]  cur_wl = WAYS_RST;
    logic [31:0] recent_addrs [$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    set_assoc_cache_tag_lookup #(.LINE_COUNT(LINES)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Check results and watch for a stalled run.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever a new ticket is issued.
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_ticket != hold_seen) begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Mix of line reuse, same-set conflicts, random and corner addresses.
    function automatic logic [31:0] next_address();
        int unsigned pick, span;
        logic [31:0] prior, low_mask, addr;
        logic [63:0] wide;
        pick = $urandom_range(99);
        span = cur_ls + LOG2_LINES - effective_ways_log2(cur_wl);
        if (recent_addrs.size() == 0 || (pick >= 75 && pick < 95)) begin
            addr = $urandom;
        end else if (pick >= 95) begin
            case ($urandom_range(3))
                0: addr = '0;
                1: addr = '1;
                2: addr = 32'(1) << $urandom_range(31);
                default: addr = ~(32'(1) << $urandom_range(31));
            endcase
        end else begin
            prior = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
            if (pick < 35) begin
                low_mask = (32'(1) << cur_ls) - 1;
                addr = (prior & ~low_mask) | ($urandom & low_mask);
            end else begin
                // Keep the set, pick from a small pool of tags.
                wide = (64'($urandom_range(15)) << span) | (64'(prior) & ((64'(1) << span) - 1));
                addr = wide[31:0];
            end
        end
        recent_addrs.push_back(addr);
        if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
        return addr;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [31:0] addr);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        do @(posedge aclk); while (!s_tready);
        board.note_request(addr);
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        board.set_register(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (board.expected_lookups.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [2:0] ls, input logic [3:0] wl, input logic [15:0] seed,
                             input int send_pct, input int sink_pct, input int count,
                             input bit hold);
        wait_drained();
        write_register(CFG_LINE_SIZE, 16'(ls));
        write_register(CFG_WAYS, 16'(wl));
        write_register(CFG_SEED, seed);
        if (hold) write_register(CFG_UNUSED, 16'($urandom));
        cur_ls = ls;
        cur_wl = wl;
        idle_pct = send_pct;
        stall_pct = sink_pct;
        if (hold) hold_ticket++;
        repeat (count) send_request(next_address());
        s_tvalid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [31:0] probe_addrs [20];
        probe_addrs = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_000F, 32'h0000_0010,
            // Fill set 0 past its eight ways to force a random eviction.
            32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 32'h0000_4000,
            32'h0000_5000, 32'h0000_6000, 32'h0000_7000, 32'h0000_8000,
            32'h0000_0000, 32'h0000_1000, 32'h0000_8004, 32'h8000_0000,
            32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
        };
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed lookups under the reset geometry.
        foreach (probe_addrs[i]) begin
            recent_addrs.push_back(probe_addrs[i]);
            send_request(probe_addrs[i]);
        end
        s_tvalid <= 1'b0;

        run_phase(3'd0, 4'd0, 16'd1, 0, 0, 250, 1'b0);
        run_phase(3'd7, 4'd11, 16'hFFFF, 18, 18, 40, 1'b0);
        run_phase(3'd5, 4'd2, 16'd0, 48, 0, 300, 1'b0);
        run_phase(3'd4, 4'd3, 16'($urandom_range(1, 65535)), 0, 48, 300, 1'b1);
        run_phase(3'd2, 4'd15, 16'($urandom_range(1, 65535)), 0, 0, 24, 1'b0);
        run_phase(3'd3, 4'd1, 16'($urandom_range(1, 65535)), 18, 18, 300, 1'b0);
        run_phase(3'd1, 4'd6, 16'($urandom_range(1, 65535)), 48, 0, 200, 1'b0);
        run_phase(3'd6, 4'd4, 16'($urandom_range(1, 65535)), 0, 48, 200, 1'b0);

        wait_drained();
        if (board.errors == 0 && board.expected_lookups.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
